// File: sv/mss_pkg.sv
`timescale 1ns / 1ps

package mss_pkg;

    localparam int OP_W      = 4;
    localparam int CODE_W    = 16;
    localparam int PHASE_W   = 4;
    localparam int SYM_W     = 11;
    localparam int RATE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int RPT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 1;

    // line events
    localparam logic [OP_W-1:0] OP_RESTART  = 4'd0;
    localparam logic [OP_W-1:0] OP_TONE     = 4'd1;
    localparam logic [OP_W-1:0] OP_CARRIER  = 4'd2;
    localparam logic [OP_W-1:0] OP_REVERSAL = 4'd3;
    localparam logic [OP_W-1:0] OP_AMP_DROP = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOTE_S = 4'd5;
    localparam logic [OP_W-1:0] OP_SEG_DONE = 4'd6;
    localparam logic [OP_W-1:0] OP_RATE     = 4'd7;
    localparam logic [OP_W-1:0] OP_REMOTE_E = 4'd8;

    // handshake phases
    localparam logic [PHASE_W-1:0] PH_WAIT_TONE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_AA         = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CC         = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_S     = 4'd3;
    localparam logic [PHASE_W-1:0] PH_AC         = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CA         = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SILENCE    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TRAIN1     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_R1         = 4'd8;
    localparam logic [PHASE_W-1:0] PH_WAIT_TRAIN = 4'd9;
    localparam logic [PHASE_W-1:0] PH_TRAIN2     = 4'd10;
    localparam logic [PHASE_W-1:0] PH_R2         = 4'd11;
    localparam logic [PHASE_W-1:0] PH_E          = 4'd12;
    localparam logic [PHASE_W-1:0] PH_ONES       = 4'd13;
    localparam logic [PHASE_W-1:0] PH_DATA       = 4'd14;
    localparam logic [PHASE_W-1:0] PH_FAILED     = 4'd15;

    // segment lengths in symbols
    localparam logic [SYM_W-1:0] LEN_NONE  = 11'd0;
    localparam logic [SYM_W-1:0] LEN_TRAIN = 11'd1552;
    localparam logic [SYM_W-1:0] LEN_LONG  = 11'd128;
    localparam logic [SYM_W-1:0] LEN_MID   = 11'd64;
    localparam logic [SYM_W-1:0] LEN_SHORT = 11'd16;

    localparam logic [RATE_W-1:0] RATE_NONE = 2'd0;
    localparam logic [RATE_W-1:0] RATE_4800 = 2'd1;
    localparam logic [RATE_W-1:0] RATE_9600 = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_ROLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_HIGH  = 2'd2;

    typedef struct packed {
        logic answer_role;
        logic allow_low_rate;
        logic allow_high_rate;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] rate_code;
        logic              code_valid;
        logic              offers_low;
        logic              offers_high;
    } event_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [SYM_W-1:0]   symbols;
        logic [CODE_W-1:0]  last_code;
        logic [RPT_W-1:0]   repeat_count;
        logic [RATE_W-1:0]  rate;
    } seq_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0]  current_phase;
        logic [SYM_W-1:0]    segment_symbols;
        logic [RATE_W-1:0]   chosen_rate;
        logic [STATUS_W-1:0] rate_status;
    } result_t;

endpackage

// File: sv/mss_event_if.sv
`timescale 1ns / 1ps

interface mss_event_if;
    import mss_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] rate_code;
    logic              code_valid;
    logic              offers_low;
    logic              offers_high;

    modport source (
        output valid, op, rate_code, code_valid, offers_low, offers_high,
        input  ready
    );

    modport sink (
        input  valid, op, rate_code, code_valid, offers_low, offers_high,
        output ready
    );
endinterface

// File: sv/mss_result_if.sv
`timescale 1ns / 1ps

interface mss_result_if;
    import mss_pkg::*;

    logic                valid;
    logic                ready;
    logic [PHASE_W-1:0]  current_phase;
    logic [SYM_W-1:0]    segment_symbols;
    logic [RATE_W-1:0]   chosen_rate;
    logic [STATUS_W-1:0] rate_status;

    modport source (
        output valid, current_phase, segment_symbols, chosen_rate, rate_status,
        input  ready
    );

    modport sink (
        input  valid, current_phase, segment_symbols, chosen_rate, rate_status,
        output ready
    );
endinterface

// File: sv/mss_step.sv
`timescale 1ns / 1ps

module mss_step (
    input  mss_pkg::cfg_t       cfg,
    input  mss_pkg::seq_state_t cur,
    input  mss_pkg::event_t     ev,
    output mss_pkg::seq_state_t nxt,
    output mss_pkg::result_t    res
);
    import mss_pkg::*;

    logic                is_call;
    logic [STATUS_W-1:0] status;
    logic [RPT_W-1:0]    rpt;
    logic [RATE_W-1:0]   pick;
    seq_state_t          st;

    // segment-done transitions, shared by segment done and remote E
    function automatic seq_state_t seg_done(input seq_state_t s);
        seq_state_t r;
        r = s;
        case (s.phase)
            PH_SILENCE:
            begin
                r.phase = PH_TRAIN1;
                r.symbols = LEN_TRAIN;
            end
            PH_TRAIN1:
            begin
                r.phase = PH_R1;
                r.symbols = LEN_NONE;
            end
            PH_WAIT_TRAIN:
            begin
                r.phase = PH_TRAIN2;
                r.symbols = LEN_TRAIN;
            end
            PH_TRAIN2:
            begin
                r.phase = PH_R2;
                r.symbols = LEN_NONE;
            end
            PH_E:
            begin
                r.phase = PH_ONES;
                r.symbols = LEN_LONG;
            end
            PH_ONES:
            begin
                r.phase = PH_DATA;
                r.symbols = LEN_NONE;
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    assign is_call = !cfg.answer_role;

    always_comb
    begin
        st     = cur;
        status = ST_NONE;
        rpt    = cur.repeat_count;
        pick   = RATE_NONE;
        case (ev.op)
            OP_RESTART:
            begin
                st.last_code    = '0;
                st.repeat_count = '0;
                st.rate         = RATE_NONE;
                st.phase        = is_call ? PH_WAIT_TONE : PH_AC;
                st.symbols      = is_call ? LEN_NONE : LEN_LONG;
            end
            OP_TONE:
            begin
                if (is_call && cur.phase == PH_WAIT_TONE)
                begin
                    st.phase   = PH_AA;
                    st.symbols = LEN_NONE;
                end
            end
            OP_CARRIER:
            begin
                if (!is_call && cur.phase == PH_AC)
                begin
                    st.phase   = PH_CA;
                    st.symbols = LEN_NONE;
                end
            end
            OP_REVERSAL:
            begin
                if (is_call && cur.phase == PH_AA)
                begin
                    st.phase   = PH_CC;
                    st.symbols = LEN_MID;
                end
                else if (is_call && cur.phase == PH_CC)
                begin
                    st.phase   = PH_WAIT_S;
                    st.symbols = LEN_NONE;
                end
                else if (!is_call && cur.phase == PH_CA)
                begin
                    st.phase   = PH_AC;
                    st.symbols = LEN_MID;
                end
            end
            OP_AMP_DROP:
            begin
                if (!is_call && cur.phase == PH_AC)
                begin
                    st.phase   = PH_SILENCE;
                    st.symbols = LEN_SHORT;
                end
            end
            OP_REMOTE_S:
            begin
                if (is_call && cur.phase == PH_WAIT_S)
                begin
                    st.phase   = PH_TRAIN1;
                    st.symbols = LEN_TRAIN;
                end
                else if (!is_call && cur.phase == PH_R1)
                begin
                    st.phase   = PH_WAIT_TRAIN;
                    st.symbols = LEN_NONE;
                end
            end
            OP_SEG_DONE:
            begin
                st = seg_done(cur);
            end
            OP_RATE:
            begin
                if ((cur.phase inside {PH_R1, PH_R2}) && ev.code_valid)
                begin
                    if (ev.rate_code == cur.last_code)
                    begin
                        // repeat count saturates at three
                        rpt = (cur.repeat_count == 2'd3) ? cur.repeat_count
                                                         : cur.repeat_count + 2'd1;
                    end
                    else
                    begin
                        rpt          = 2'd1;
                        st.last_code = ev.rate_code;
                    end
                    st.repeat_count = rpt;
                    if (rpt >= 2'd2)
                    begin
                        if (cfg.allow_high_rate && ev.offers_high)
                        begin
                            pick = RATE_9600;
                        end
                        else if (cfg.allow_low_rate && ev.offers_low)
                        begin
                            pick = RATE_4800;
                        end
                        st.rate = pick;
                        if (pick == RATE_NONE)
                        begin
                            st.phase   = PH_FAILED;
                            st.symbols = LEN_NONE;
                            status     = ST_FAIL;
                        end
                        else
                        begin
                            st.phase   = PH_E;
                            st.symbols = LEN_SHORT;
                            status     = ST_ACCEPT;
                        end
                    end
                end
            end
            OP_REMOTE_E:
            begin
                if (cur.phase == PH_E)
                begin
                    st = seg_done(cur);
                end
            end
            default:
            begin
                st = cur;
            end
        endcase
    end

    assign nxt = st;

    assign res.current_phase   = st.phase;
    assign res.segment_symbols = st.symbols;
    assign res.chosen_rate     = st.rate;
    assign res.rate_status     = status;

endmodule

// File: sv/modem_startup_sequencer_top.sv
`timescale 1ns / 1ps

// an accepted item is held in the input register, then its result is registered in the result register
// throughput: one item per cycle while results are taken, set by the combinational state update in mss_step
// a waiting result holds the next item in the input register, then the input stalls
// reset: asynchronous, active low; phase wait tone, lengths, last code, repeat count,
// rate and configuration cleared to zero; no clearing pass

module modem_startup_sequencer_top (
    input  logic                       clk,
    input  logic                       rst_n,
    mss_event_if.sink                  event_ch,
    mss_result_if.source               result_ch,
    input  logic                       wr_en,
    input  logic [mss_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [mss_pkg::CFG_DAT_W-1:0] wr_data
);
    import mss_pkg::*;

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    event_t     ev_reg;
    event_t     ev_in;
    logic       ev_valid_reg;
    result_t    res_next;
    result_t    res_reg;
    logic       res_valid_reg;
    logic       advance;
    logic       take;

    // the stored item moves on when the result slot is free or drains this cycle
    assign advance = ev_valid_reg && (!res_valid_reg || result_ch.ready);
    assign event_ch.ready = !ev_valid_reg || advance;
    assign take = event_ch.valid && event_ch.ready;

    assign ev_in.op          = event_ch.op;
    assign ev_in.rate_code   = event_ch.rate_code;
    assign ev_in.code_valid  = event_ch.code_valid;
    assign ev_in.offers_low  = event_ch.offers_low;
    assign ev_in.offers_high = event_ch.offers_high;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ANSWER_ROLE: cfg_reg.answer_role     <= wr_data[0];
                REG_ALLOW_LOW:   cfg_reg.allow_low_rate  <= wr_data[0];
                REG_ALLOW_HIGH:  cfg_reg.allow_high_rate <= wr_data[0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    mss_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .ev  (ev_reg),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                ev_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                ev_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg <= ev_in;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_ch.valid           = res_valid_reg;
    assign result_ch.current_phase   = res_reg.current_phase;
    assign result_ch.segment_symbols = res_reg.segment_symbols;
    assign result_ch.chosen_rate     = res_reg.chosen_rate;
    assign result_ch.rate_status     = res_reg.rate_status;

    a_rate_only_after_success: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.rate != RATE_NONE) |->
        (state_reg.phase == PH_E || state_reg.phase == PH_ONES ||
         state_reg.phase == PH_DATA))
        else $error("rate held outside E, ones or data phase");

    a_failed_has_no_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_FAILED) |-> (state_reg.rate == RATE_NONE))
        else $error("failed phase with a rate selected");

    a_advance_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_valid_reg && res_reg.current_phase == state_reg.phase))
        else $error("result register does not match updated state");

    a_fail_status_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.rate_status == ST_FAIL) |->
        (res_reg.chosen_rate == RATE_NONE && res_reg.current_phase == PH_FAILED))
        else $error("failed status with inconsistent phase or rate");

endmodule
